### hw/rtl/stw_pkg.sv
// shared constants, codes and control types of the sliding time window statistics block
`default_nettype none
package stw_pkg;
   localparam int DEF_WINDOW_DEPTH = 32;
   localparam int DEF_TIME_BITS    = 48;
   localparam int DEF_VALUE_BITS   = 32;

   localparam int RES_BITS       = 64;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 2;
   localparam int MODE_BITS      = 4;
   localparam int FLAG_BITS      = 3;

   localparam int FRAME_OVERHEAD = 38;
   localparam int PERCENT        = 100;
   localparam int GAP_FACTOR     = 2;

   localparam logic [63:0]                WINDOW_RESET  = 64'd1000000000000;
   localparam logic [MODE_BITS-1:0]       MODE_RESET    = 4'd0;
   localparam logic [CSR_DATA_BITS-1:0]   DIVISOR_RESET = 48'd1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIVISOR = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_COUNT = 4'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUM   = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_AVG   = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_MIN   = 4'd3;
   localparam logic [MODE_BITS-1:0] MODE_MAX   = 4'd4;
   localparam logic [MODE_BITS-1:0] MODE_RANGE = 4'd5;
   localparam logic [MODE_BITS-1:0] MODE_EFF   = 4'd6;
   localparam logic [MODE_BITS-1:0] MODE_UTIL  = 4'd7;
   localparam logic [MODE_BITS-1:0] MODE_AVAIL = 4'd8;

   localparam logic [1:0] KIND_EVICT = 2'd0;
   localparam logic [1:0] KIND_GAP   = 2'd1;
   localparam logic [1:0] KIND_FINAL = 2'd2;
   localparam logic [1:0] KIND_TERR  = 2'd3;

   typedef struct packed {
      logic       load;
      logic       rd_oldest;
      logic       evict;
      logic       rd_newest;
      logic       store;
      logic       set_prev;
      logic       scan_start;
      logic       div_start;
      logic       emit;
      logic [1:0] kind;
   } stw_cmd_type;

   typedef struct packed {
      logic lt_prev;
      logic can_evict;
      logic expired;
      logic gap;
      logic has_entries;
      logic dup;
      logic need_scan;
      logic need_div;
      logic scan_done;
      logic div_busy;
      logic out_free;
   } stw_sts_type;
endpackage
`default_nettype wire

### hw/rtl/sliding_time_window_statistics.sv
// sliding time window statistics, top level
// per result beat, min, max and range scan the store, divide modes run the radix-2 divider,
//   and count, sum, empty window and unused modes need neither; a gap beat skips both;
//   output stalls hold the beat in the output register
// each expired entry adds one result beat; up to depth + 2 beats per sample
// one sample at a time; the next is taken once the final beat sits in the output register
// synchronous active-high reset clears the window, previous time and registers to defaults
`default_nettype none
module sliding_time_window_statistics
   import stw_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int TIME_BITS    = DEF_TIME_BITS,
   parameter int VALUE_BITS   = DEF_VALUE_BITS,
   localparam int REQ_BITS    = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS    = ((TIME_BITS + RES_BITS + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_BITS-1:0]       req_tdata,   // sample_time, sample_value
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_BITS-1:0]            rsp_tdata,   // result_time, result_value
   output logic [FLAG_BITS-1:0]           rsp_tuser,   // window_empty, time_error, window_full
   output logic                           rsp_tlast,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);
   stw_cmd_type cmd;
   stw_sts_type sts;

   stw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stw_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .TIME_BITS    (TIME_BITS),
      .VALUE_BITS   (VALUE_BITS),
      .REQ_BITS     (REQ_BITS),
      .RSP_BITS     (RSP_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );
endmodule
`default_nettype wire

### hw/rtl/stw_ram.sv
// generic single write port ram with registered read
`default_nettype none
module stw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### hw/rtl/stw_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module stw_div
   import stw_pkg::*;
#(
   parameter int WIDTH = RES_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [WIDTH-1:0] dividend,
   input  wire logic signed [WIDTH-1:0] divisor,
   output logic                         busy,
   output logic signed [WIDTH-1:0]      quotient
);
   localparam int CNT_BITS = $clog2(WIDTH + 1);

   logic [WIDTH:0]         rem_ff, rem_in;
   logic [WIDTH-1:0]       quo_ff, quo_in;
   logic [WIDTH-1:0]       dvs_ff, dvs_in;
   logic                   neg_ff, neg_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [WIDTH:0]         rem_sh;
   logic [WIDTH:0]         diff;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      rem_sh = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[WIDTH-1] ? -dividend : dividend;
         dvs_in = divisor[WIDTH-1] ? -divisor : divisor;
         neg_in = dividend[WIDTH-1] ^ divisor[WIDTH-1];
         cnt_in = CNT_BITS'(WIDTH);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!diff[WIDTH]) begin
            rem_in = diff;
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule
`default_nettype wire

### hw/rtl/stw_datapath.sv
// window store, running total, min and max scan, statistic and result register
`default_nettype none
module stw_datapath
   import stw_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int TIME_BITS    = DEF_TIME_BITS,
   parameter int VALUE_BITS   = DEF_VALUE_BITS,
   parameter int REQ_BITS     = ((DEF_TIME_BITS + DEF_VALUE_BITS + 7) / 8) * 8,
   parameter int RSP_BITS     = ((DEF_TIME_BITS + RES_BITS + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire stw_cmd_type               cmd,
   output stw_sts_type                    sts,
   input  wire logic [REQ_BITS-1:0]       req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_BITS-1:0]            rsp_tdata,
   output logic [FLAG_BITS-1:0]           rsp_tuser,
   output logic                           rsp_tlast,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);
   localparam int IDX_BITS   = $clog2(WINDOW_DEPTH);
   localparam int CNT_BITS   = $clog2(WINDOW_DEPTH + 1);
   localparam int TOTAL_BITS = VALUE_BITS + CNT_BITS + 1;
   localparam logic [63:0] WL_RESET64 = WINDOW_RESET;
   localparam logic signed [RES_BITS-1:0] PERCENT_Q = RES_BITS'(PERCENT) <<< FRAC_BITS;

   function automatic logic [IDX_BITS-1:0] slot_add(input logic [IDX_BITS-1:0] base,
                                                    input logic [IDX_BITS:0] inc);
      logic [IDX_BITS:0] s;
      s = {1'b0, base} + inc;
      if (s >= (IDX_BITS+1)'(WINDOW_DEPTH)) begin
         s = s - (IDX_BITS+1)'(WINDOW_DEPTH);
      end
      return s[IDX_BITS-1:0];
   endfunction

   logic [TIME_BITS-1:0]            wl_ff, wl_in;
   logic [MODE_BITS-1:0]            mode_ff, mode_in;
   logic [CSR_DATA_BITS-1:0]        pd_ff, pd_in;
   logic [63:0]                     csr_ext;

   logic [TIME_BITS-1:0]            t_ff, t_in;
   logic signed [VALUE_BITS-1:0]    val_ff, val_in;
   logic [TIME_BITS-1:0]            prev_ff, prev_in;
   logic [IDX_BITS-1:0]             oldest_ff, oldest_in;
   logic [CNT_BITS-1:0]             cnt_ff, cnt_in;
   logic signed [TOTAL_BITS-1:0]    total_ff, total_in;
   logic [TIME_BITS-1:0]            et_ff, et_in;
   logic                            full_ff, full_in;

   logic [IDX_BITS-1:0]             scan_ptr_ff, scan_ptr_in;
   logic [CNT_BITS-1:0]             scan_left_ff, scan_left_in;
   logic                            pend_ff, pend_in;
   logic                            first_ff, first_in;
   logic signed [VALUE_BITS-1:0]    lo_ff, lo_in, hi_ff, hi_in;

   logic                            out_valid_ff, out_valid_in;
   logic [RSP_BITS-1:0]             out_data_ff, out_data_in;
   logic [FLAG_BITS-1:0]            out_user_ff, out_user_in;
   logic                            out_last_ff, out_last_in;

   logic                            scan_active;
   logic                            rd_en, wr_en;
   logic [IDX_BITS-1:0]             rd_addr, wr_addr, newest;
   logic [TIME_BITS-1:0]            ram_time;
   logic [VALUE_BITS-1:0]           ram_value;
   logic signed [VALUE_BITS-1:0]    ram_sval;

   logic [TIME_BITS-1:0]            t_minus_w;
   logic [TIME_BITS:0]              et_sum;
   logic [TIME_BITS+1:0]            gap_d, gap_lim;

   logic signed [RES_BITS-1:0]      n64, s64, lo64, hi64, den, pd64;
   logic signed [RES_BITS-1:0]      div_a, div_b, quo, stat_val;
   logic                            div_busy;
   logic                            out_free, is_empty;
   logic [TIME_BITS-1:0]            res_time;
   logic signed [RES_BITS-1:0]      res_val;
   logic                            res_empty;

   stw_ram #(.WIDTH(TIME_BITS), .DEPTH(WINDOW_DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (t_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_time)
   );

   stw_ram #(.WIDTH(VALUE_BITS), .DEPTH(WINDOW_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_value)
   );

   stw_div #(.WIDTH(RES_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign ram_sval    = $signed(ram_value);
   assign scan_active = (scan_left_ff != '0);
   assign newest      = slot_add(oldest_ff, (IDX_BITS+1)'(cnt_ff) - 1'b1);
   assign wr_addr     = slot_add(oldest_ff, (IDX_BITS+1)'(cnt_ff));
   assign wr_en       = cmd.store && (cnt_ff < CNT_BITS'(WINDOW_DEPTH));
   assign rd_en       = scan_active || cmd.rd_oldest || cmd.rd_newest;
   assign csr_ext     = 64'(csr_wdata);
   assign csr_ready   = 1'b1;
   assign out_free    = !out_valid_ff || rsp_tready;
   assign is_empty    = (cnt_ff == '0);

   always_comb begin
      priority if (scan_active) begin
         rd_addr = scan_ptr_ff;
      end else if (cmd.rd_oldest) begin
         rd_addr = oldest_ff;
      end else begin
         rd_addr = newest;
      end
   end

   // time compares
   always_comb begin
      t_minus_w = t_ff - wl_ff;
      et_sum    = {1'b0, ram_time} + {1'b0, wl_ff};
      gap_d     = (TIME_BITS+2)'(t_ff - prev_ff);
      gap_lim   = (TIME_BITS+2)'(wl_ff) * (TIME_BITS+2)'(GAP_FACTOR);
   end

   // statistic operands
   always_comb begin
      n64  = RES_BITS'(cnt_ff);
      s64  = RES_BITS'(total_ff);
      lo64 = RES_BITS'(lo_ff);
      hi64 = RES_BITS'(hi_ff);
      den  = s64 + n64 * RES_BITS'(FRAME_OVERHEAD);
      pd64 = (pd_ff == '0) ? RES_BITS'(1) : RES_BITS'(pd_ff);
      unique case (mode_ff)
         MODE_AVG: begin
            div_a = s64 <<< FRAC_BITS;
            div_b = n64;
         end
         MODE_EFF: begin
            div_a = (s64 * RES_BITS'(PERCENT)) <<< FRAC_BITS;
            div_b = den;
         end
         default: begin
            div_a = s64 <<< FRAC_BITS;
            div_b = pd64;
         end
      endcase
      unique case (mode_ff)
         MODE_COUNT: stat_val = n64 <<< FRAC_BITS;
         MODE_SUM:   stat_val = s64 <<< FRAC_BITS;
         MODE_AVG:   stat_val = quo;
         MODE_MIN:   stat_val = lo64 <<< FRAC_BITS;
         MODE_MAX:   stat_val = hi64 <<< FRAC_BITS;
         MODE_RANGE: stat_val = (hi64 - lo64) <<< FRAC_BITS;
         MODE_EFF:   stat_val = (den == '0) ? '0 : quo;
         MODE_UTIL:  stat_val = quo;
         MODE_AVAIL: stat_val = PERCENT_Q - quo;
         default:    stat_val = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.kind)
         KIND_EVICT: res_time = et_ff;
         KIND_GAP:   res_time = t_minus_w;
         default:    res_time = t_ff;
      endcase
      res_empty = (cmd.kind == KIND_GAP) || is_empty;
      res_val   = res_empty ? '0 : stat_val;
   end

   always_comb begin
      sts.lt_prev     = (t_ff < prev_ff);
      sts.can_evict   = !is_empty && (t_ff >= wl_ff);
      sts.expired     = (ram_time < t_minus_w);
      sts.gap         = (gap_d > gap_lim);
      sts.has_entries = !is_empty;
      sts.dup         = (ram_time == t_ff);
      sts.need_scan   = !is_empty && (mode_ff == MODE_MIN || mode_ff == MODE_MAX ||
                                      mode_ff == MODE_RANGE);
      sts.need_div    = !is_empty && (mode_ff == MODE_AVG || mode_ff == MODE_EFF ||
                                      mode_ff == MODE_UTIL || mode_ff == MODE_AVAIL);
      sts.scan_done   = !scan_active && !pend_ff;
      sts.div_busy    = div_busy;
      sts.out_free    = out_free;
   end

   always_comb begin
      wl_in        = wl_ff;
      mode_in      = mode_ff;
      pd_in        = pd_ff;
      t_in         = t_ff;
      val_in       = val_ff;
      prev_in      = prev_ff;
      oldest_in    = oldest_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      et_in        = et_ff;
      full_in      = full_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      pend_in      = 1'b0;
      first_in     = first_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_WINDOW:  wl_in   = csr_ext[TIME_BITS-1:0];
            REG_MODE:    mode_in = csr_wdata[MODE_BITS-1:0];
            REG_DIVISOR: pd_in   = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         t_in    = (TIME_BITS)'(req_tdata[TIME_BITS-1:0]);
         val_in  = $signed(req_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS]);
         full_in = 1'b0;
      end

      if (cmd.evict) begin
         total_in  = total_ff - TOTAL_BITS'(ram_sval);
         oldest_in = slot_add(oldest_ff, (IDX_BITS+1)'(1));
         cnt_in    = cnt_ff - 1'b1;
         et_in     = et_sum[TIME_BITS] ? '1 : et_sum[TIME_BITS-1:0];
      end

      if (cmd.store) begin
         if (wr_en) begin
            cnt_in   = cnt_ff + 1'b1;
            total_in = total_ff + TOTAL_BITS'(val_ff);
         end else begin
            full_in = 1'b1;
         end
      end

      if (cmd.store || cmd.set_prev) begin
         prev_in = t_ff;
      end

      if (cmd.scan_start) begin
         scan_ptr_in  = oldest_ff;
         scan_left_in = cnt_ff;
         first_in     = 1'b1;
      end else if (scan_active) begin
         scan_ptr_in  = slot_add(scan_ptr_ff, (IDX_BITS+1)'(1));
         scan_left_in = scan_left_ff - 1'b1;
         pend_in      = 1'b1;
      end

      if (pend_ff) begin
         first_in = 1'b0;
         if (first_ff || ram_sval < lo_ff) begin
            lo_in = ram_sval;
         end
         if (first_ff || ram_sval > hi_ff) begin
            hi_in = ram_sval;
         end
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_data_in  = RSP_BITS'({res_val, res_time});
         out_user_in  = {cmd.kind == KIND_FINAL && full_ff, cmd.kind == KIND_TERR, res_empty};
         out_last_in  = (cmd.kind == KIND_FINAL) || (cmd.kind == KIND_TERR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff        <= WL_RESET64[TIME_BITS-1:0];
         mode_ff      <= MODE_RESET;
         pd_ff        <= DIVISOR_RESET;
         prev_ff      <= '0;
         oldest_ff    <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         full_ff      <= 1'b0;
         scan_left_ff <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wl_ff        <= wl_in;
         mode_ff      <= mode_in;
         pd_ff        <= pd_in;
         prev_ff      <= prev_in;
         oldest_ff    <= oldest_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         full_ff      <= full_in;
         scan_left_ff <= scan_left_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
      t_ff        <= t_in;
      val_ff      <= val_in;
      et_ff       <= et_in;
      scan_ptr_ff <= scan_ptr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

### hw/rtl/stw_ctrl.sv
// sequencer for eviction, gap point, store, statistic and result beats
`default_nettype none
module stw_ctrl
   import stw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire stw_sts_type sts,
   output stw_cmd_type      cmd
);
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_EV_RD    = 4'd2;
   localparam logic [3:0] S_EV_WAIT  = 4'd3;
   localparam logic [3:0] S_GAP      = 4'd4;
   localparam logic [3:0] S_DUP_RD   = 4'd5;
   localparam logic [3:0] S_DUP_WAIT = 4'd6;
   localparam logic [3:0] S_STORE    = 4'd7;
   localparam logic [3:0] S_STAT     = 4'd8;
   localparam logic [3:0] S_SCAN     = 4'd9;
   localparam logic [3:0] S_DIV      = 4'd10;
   localparam logic [3:0] S_EMIT     = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.lt_prev) begin
               kind_in  = KIND_TERR;
               state_in = S_STAT;
            end else begin
               state_in = S_EV_RD;
            end
         end
         S_EV_RD: begin
            if (sts.can_evict) begin
               cmd.rd_oldest = 1'b1;
               state_in      = S_EV_WAIT;
            end else begin
               state_in = S_GAP;
            end
         end
         S_EV_WAIT: begin
            if (sts.expired) begin
               cmd.evict = 1'b1;
               kind_in   = KIND_EVICT;
               state_in  = S_STAT;
            end else begin
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            if (sts.gap) begin
               kind_in  = KIND_GAP;
               state_in = S_EMIT;
            end else begin
               state_in = S_DUP_RD;
            end
         end
         S_DUP_RD: begin
            if (sts.has_entries) begin
               cmd.rd_newest = 1'b1;
               state_in      = S_DUP_WAIT;
            end else begin
               state_in = S_STORE;
            end
         end
         S_DUP_WAIT: begin
            if (sts.dup) begin
               cmd.set_prev = 1'b1;
               kind_in      = KIND_FINAL;
               state_in     = S_STAT;
            end else begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            kind_in   = KIND_FINAL;
            state_in  = S_STAT;
         end
         S_STAT: begin
            priority if (sts.need_scan) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               unique case (kind_ff)
                  KIND_EVICT: state_in = S_EV_RD;
                  KIND_GAP:   state_in = S_DUP_RD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_FINAL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
endmodule
`default_nettype wire

### hw/rtl/stw_checker.sv
// port-level checks of the sliding time window statistics block and their binding
`default_nettype none
module stw_checker
   import stw_pkg::*;
#(
   parameter int TIME_BITS  = DEF_TIME_BITS,
   localparam int RSP_BITS  = ((TIME_BITS + RES_BITS + 7) / 8) * 8
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_BITS-1:0]       rsp_tdata,
   input wire logic [FLAG_BITS-1:0]      rsp_tuser,
   input wire logic                      rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample taken while previous sample in work");

   a_flags_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2]) |-> rsp_tlast)
      else $error("error flag on a non-final beat");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[TIME_BITS+RES_BITS-1:TIME_BITS] == '0)
      else $error("empty window with nonzero value");
endmodule

bind sliding_time_window_statistics stw_checker #(
   .TIME_BITS  (TIME_BITS)
) u_stw_checker (.*);
`default_nettype wire
